>>> hdl/mvul_pkg.sv
//------------------------------------------------------------------------------
// mvul_pkg: shared types and constants of the mecanum velocity update
// Fixed-point constants, register indexes and the sequencer state type.
//------------------------------------------------------------------------------
`default_nettype none
package mvul_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SCALE_BITS = 28;

    localparam logic [31:0] INV_INERTIA_Q30 = 32'd249707401;
    localparam logic [31:0] L_OVER_R_Q24    = 32'd129429511;

    localparam logic [16:0] TIME_STEP_RST   = 17'd655;
    localparam logic [30:0] SPEED_LIMIT_RST = 31'd1385776;
    localparam logic [30:0] ACCEL_LIMIT_RST = 31'd8612866;

    localparam logic [1:0] REG_TIME_STEP   = 2'd0;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [1:0] REG_ACCEL_LIMIT = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_INERTIA,
        ST_AROT,
        ST_AMAX,
        ST_ADIV,
        ST_ASCALE,
        ST_INTEG,
        ST_VROT,
        ST_VMAX,
        ST_VDIV,
        ST_VSCALE,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> hdl/mecanum_velocity_update_limited.sv
//------------------------------------------------------------------------------
// mecanum_velocity_update_limited: limited velocity update of a mecanum base
// One input word carries op and a force command; one output word carries the
// new body velocity and the two limit flags.
//
// s_axis_* accepts a command word (tuser = op, tdata = force_x, force_y,
// torque_z). m_axis_* presents the result (tdata = vel_x, vel_y, yaw_rate,
// tuser = accel_limited, speed_limited). Configuration is a plain write port.
// A small sequencer drives one shared 32x32-bit signed multiplier (one product
// per cycle) and one restoring divider that yields one quotient bit per cycle.
// A force step scales the torque by the inverse inertia, forms the rotation
// term and compares the peak wheel value to the acceleration limit; each hit
// limit adds a 64-step division and three scaling products. The step then
// integrates the three elements, checks the speed limit the same way and
// registers the result. A clear goes straight to the output state. The next
// word is taken in the cycle after the result is taken at the earliest.
// s_axis_tready is low while a word is in work and while a result waits on a
// stalled receiver; the result holds until taken.
// Reset clears the stored velocity and loads the register reset values.
//------------------------------------------------------------------------------
`default_nettype none
module mecanum_velocity_update_limited (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: force_x[31:0], force_y[63:32], torque_z[95:64]
    input  wire logic [95:0]  s_axis_tdata,
    // tuser: op
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: vel_x[31:0], vel_y[63:32], yaw_rate[95:64]
    output logic [95:0]       m_axis_tdata,
    // tuser: accel_limited[0], speed_limited[1]
    output logic [1:0]        m_axis_tuser,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);

    mvul_pkg::state_t state_reg, state_next;

    logic [16:0] ts_reg;
    logic [30:0] spd_lim_reg, acc_lim_reg;
    logic signed [31:0] bv_reg [3];
    logic signed [63:0] w_reg [3];       // working vector
    logic signed [63:0] rot_reg, max_reg;
    logic [1:0]  idx_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg, rem_reg;
    logic [31:0] quo_reg;
    logic        acc_f_reg, spd_f_reg, out_v_reg;

    // Round to nearest, ties toward plus infinity: arithmetic shift after bias.
    function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                  input int n);
        logic signed [63:0] t;
        begin
            t = v + (64'sd1 <<< (n - 1));
            rshift = t >>> n;
        end
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) sat32 = 64'sd2147483647;
            else if (v < -64'sd2147483648) sat32 = -64'sd2147483648;
            else sat32 = v;
        end
    endfunction

    function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
        begin
            abs64 = v[63] ? -v : v;
        end
    endfunction

    // Shared product unit: operands chosen by the sequencer. Every operand
    // fits in 32 signed bits; the quotient stays below 2^28.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    assign prod = mul_a * mul_b;

    // Largest wheel magnitude of the four wheels, from w_reg[0], w_reg[1] and rot_reg.
    logic signed [63:0] wsum, wdif, mag;
    always_comb
    begin
        wsum = 64'sd20 * (w_reg[0] + w_reg[1]);
        wdif = 64'sd20 * (w_reg[0] - w_reg[1]);
        mag  = abs64(wdif - rot_reg);
        if (abs64(wsum + rot_reg) > mag) mag = abs64(wsum + rot_reg);
        if (abs64(wsum - rot_reg) > mag) mag = abs64(wsum - rot_reg);
        if (abs64(wdif + rot_reg) > mag) mag = abs64(wdif + rot_reg);
    end

    // Divider step: one quotient bit per cycle.
    logic [64:0] rem_try;
    assign rem_try = {rem_reg, num_reg[63]} - {1'b0, max_reg};

    always_comb
    begin
        mul_a = w_reg[idx_reg][31:0];
        mul_b = 32'(signed'({1'b0, ts_reg}));
        case (state_reg)
            mvul_pkg::ST_INERTIA:
            begin
                mul_a = w_reg[2][31:0];
                mul_b = signed'(mvul_pkg::INV_INERTIA_Q30);
            end
            mvul_pkg::ST_AROT, mvul_pkg::ST_VROT:
            begin
                mul_a = w_reg[2][31:0];
                mul_b = signed'(mvul_pkg::L_OVER_R_Q24);
            end
            mvul_pkg::ST_ASCALE, mvul_pkg::ST_VSCALE:
                mul_b = signed'(quo_reg);
            default: ;
        endcase
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvul_pkg::ST_IDLE:
                if (s_axis_tvalid && !out_v_reg)
                    state_next = s_axis_tuser ? mvul_pkg::ST_OUT : mvul_pkg::ST_INERTIA;
            mvul_pkg::ST_INERTIA: state_next = mvul_pkg::ST_AROT;
            mvul_pkg::ST_AROT:    state_next = mvul_pkg::ST_AMAX;
            mvul_pkg::ST_AMAX:
                state_next = (mag > 64'(signed'({1'b0, acc_lim_reg})))
                           ? mvul_pkg::ST_ADIV : mvul_pkg::ST_INTEG;
            mvul_pkg::ST_ADIV:
                if (cnt_reg == 6'd63) state_next = mvul_pkg::ST_ASCALE;
            mvul_pkg::ST_ASCALE:
                if (idx_reg == 2'd2) state_next = mvul_pkg::ST_INTEG;
            mvul_pkg::ST_INTEG:
                if (idx_reg == 2'd2) state_next = mvul_pkg::ST_VROT;
            mvul_pkg::ST_VROT:    state_next = mvul_pkg::ST_VMAX;
            mvul_pkg::ST_VMAX:
                state_next = (mag > 64'(signed'({1'b0, spd_lim_reg})))
                           ? mvul_pkg::ST_VDIV : mvul_pkg::ST_OUT;
            mvul_pkg::ST_VDIV:
                if (cnt_reg == 6'd63) state_next = mvul_pkg::ST_VSCALE;
            mvul_pkg::ST_VSCALE:
                if (idx_reg == 2'd2) state_next = mvul_pkg::ST_OUT;
            mvul_pkg::ST_OUT:     state_next = mvul_pkg::ST_IDLE;
            default:              state_next = mvul_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == mvul_pkg::ST_IDLE) && !out_v_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mvul_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control, configuration and stored velocity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg      <= mvul_pkg::TIME_STEP_RST;
            spd_lim_reg <= mvul_pkg::SPEED_LIMIT_RST;
            acc_lim_reg <= mvul_pkg::ACCEL_LIMIT_RST;
            bv_reg[0]   <= '0;
            bv_reg[1]   <= '0;
            bv_reg[2]   <= '0;
            out_v_reg   <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            acc_f_reg   <= 1'b0;
            spd_f_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mvul_pkg::REG_TIME_STEP:   ts_reg      <= cfg_data[16:0];
                    mvul_pkg::REG_SPEED_LIMIT: spd_lim_reg <= cfg_data;
                    mvul_pkg::REG_ACCEL_LIMIT: acc_lim_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_v_reg && m_axis_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                mvul_pkg::ST_IDLE:
                begin
                    idx_reg   <= '0;
                    cnt_reg   <= '0;
                    acc_f_reg <= 1'b0;
                    spd_f_reg <= 1'b0;
                    if (s_axis_tvalid && !out_v_reg && s_axis_tuser)
                    begin
                        bv_reg[0] <= '0;
                        bv_reg[1] <= '0;
                        bv_reg[2] <= '0;
                    end
                end
                mvul_pkg::ST_AMAX:  acc_f_reg <= (mag > 64'(signed'({1'b0, acc_lim_reg})));
                mvul_pkg::ST_VMAX:  spd_f_reg <= (mag > 64'(signed'({1'b0, spd_lim_reg})));
                mvul_pkg::ST_ADIV, mvul_pkg::ST_VDIV:
                    cnt_reg <= cnt_reg + 6'd1;
                mvul_pkg::ST_ASCALE, mvul_pkg::ST_INTEG, mvul_pkg::ST_VSCALE:
                begin
                    cnt_reg <= '0;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                mvul_pkg::ST_OUT:
                begin
                    out_v_reg <= 1'b1;
                    bv_reg[0] <= w_reg[0][31:0];
                    bv_reg[1] <= w_reg[1][31:0];
                    bv_reg[2] <= w_reg[2][31:0];
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mvul_pkg::ST_IDLE:
            begin
                if (s_axis_tuser)
                begin
                    w_reg[0] <= '0;
                    w_reg[1] <= '0;
                    w_reg[2] <= '0;
                end
                else
                begin
                    w_reg[0] <= rshift(64'(signed'(s_axis_tdata[31:0])), 5);
                    w_reg[1] <= rshift(64'(signed'(s_axis_tdata[63:32])), 5);
                    w_reg[2] <= 64'(signed'(s_axis_tdata[95:64]));
                end
            end
            mvul_pkg::ST_INERTIA: w_reg[2] <= rshift(prod, 30);
            mvul_pkg::ST_AROT, mvul_pkg::ST_VROT: rot_reg <= rshift(prod, 24);
            mvul_pkg::ST_AMAX, mvul_pkg::ST_VMAX:
            begin
                max_reg <= mag;
                num_reg <= (state_reg == mvul_pkg::ST_AMAX)
                         ? {5'd0, acc_lim_reg, 28'd0} : {5'd0, spd_lim_reg, 28'd0};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            mvul_pkg::ST_ADIV, mvul_pkg::ST_VDIV:
            begin
                num_reg <= {num_reg[62:0], 1'b0};
                if (!rem_try[64])
                begin
                    rem_reg <= rem_try[63:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[62:0], num_reg[63]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
            mvul_pkg::ST_ASCALE:
                w_reg[idx_reg] <= rshift(prod, mvul_pkg::SCALE_BITS);
            mvul_pkg::ST_VSCALE:
                w_reg[idx_reg] <= sat32(rshift(prod, mvul_pkg::SCALE_BITS));
            mvul_pkg::ST_INTEG:
                w_reg[idx_reg] <= sat32(64'(bv_reg[idx_reg])
                                 + rshift(prod, mvul_pkg::FRAC_BITS));
            default: ;
        endcase
        if (state_reg == mvul_pkg::ST_OUT)
        begin
            m_axis_tdata <= {w_reg[2][31:0], w_reg[1][31:0], w_reg[0][31:0]};
            m_axis_tuser <= {spd_f_reg, acc_f_reg};
        end
    end

    assign m_axis_tvalid = out_v_reg;

endmodule
`default_nettype wire

>>> hdl/mvul_checker.sv
//------------------------------------------------------------------------------
// mvul_checker: port-level checks of the mecanum velocity update
// Watches the stream handshakes of the top level.
//------------------------------------------------------------------------------
`default_nettype none
module mvul_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A result word holds while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result word changed under stall");

    // No new command is taken while a result is waiting.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("ready while result pending");

    // An accepted command is not followed by ready in the next cycle.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

endmodule

bind mecanum_velocity_update_limited mvul_checker u_mvul_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

>>> tb/sv/mecanum_velocity_update_limited_tb.sv
//------------------------------------------------------------------------------
// mecanum_velocity_update_limited_tb: self-checking bench of the velocity update
// Drives force and clear commands under several limit and step settings,
// predicts each new body velocity and limit flags, and checks every result
// word against the oldest prediction while both sides idle at random.
//------------------------------------------------------------------------------
`default_nettype none
module mecanum_velocity_update_limited_tb;

    localparam int LATENCY   = 200;
    localparam int MAX_CYCLE = 900000;
    localparam logic [1:0] REG_INDEX_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] wz;
        logic        acc_lim;
        logic        spd_lim;
    } velocity_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    // Predictor state: stored velocity and register copies.
    longint     vel_state [3];
    longint     step_reg;
    longint     speed_reg;
    longint     accel_reg;
    velocity_t  expected_q [$];
    int         errors = 0;
    int         cycle;
    int         burst_left;
    int         gap_left;

    mecanum_velocity_update_limited dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Rounding right shift, ties toward plus infinity.
    function automatic longint rshift_round(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Largest wheel magnitude for a body vector.
    function automatic longint wheel_peak(longint bx, longint by, longint bw);
        longint rot;
        longint w [4];
        longint m;
        rot = rshift_round(bw * longint'(mvul_pkg::L_OVER_R_Q24), 24);
        w[0] = 20 * (bx - by) - rot;
        w[1] = 20 * (bx + by) + rot;
        w[2] = 20 * (bx + by) - rot;
        w[3] = 20 * (bx - by) + rot;
        m = 0;
        foreach (w[i])
            if (abs64(w[i]) > m)
                m = abs64(w[i]);
        return m;
    endfunction

    // Computes the next velocity for one command and advances the state.
    function automatic velocity_t next_velocity(logic clear, logic [95:0] cmd);
        longint a [3];
        longint v [3];
        longint m;
        longint s;
        velocity_t r;
        r = '0;
        if (clear)
        begin
            foreach (vel_state[i])
                vel_state[i] = 0;
        end
        else
        begin
            a[0] = rshift_round(longint'($signed(cmd[31:0])), 5);
            a[1] = rshift_round(longint'($signed(cmd[63:32])), 5);
            a[2] = rshift_round(longint'($signed(cmd[95:64])) *
                                longint'(mvul_pkg::INV_INERTIA_Q30), 30);
            m = wheel_peak(a[0], a[1], a[2]);
            if (m > accel_reg)
            begin
                r.acc_lim = 1'b1;
                s = (accel_reg << mvul_pkg::SCALE_BITS) / m;
                foreach (a[i])
                    a[i] = rshift_round(a[i] * s, mvul_pkg::SCALE_BITS);
            end
            foreach (v[i])
                v[i] = sat32(vel_state[i]
                             + rshift_round(a[i] * step_reg, mvul_pkg::FRAC_BITS));
            m = wheel_peak(v[0], v[1], v[2]);
            if (m > speed_reg)
            begin
                r.spd_lim = 1'b1;
                s = (speed_reg << mvul_pkg::SCALE_BITS) / m;
                foreach (v[i])
                    v[i] = sat32(rshift_round(v[i] * s, mvul_pkg::SCALE_BITS));
            end
            foreach (v[i])
                vel_state[i] = v[i];
        end
        r.vx = vel_state[0][31:0];
        r.vy = vel_state[1][31:0];
        r.wz = vel_state[2][31:0];
        return r;
    endfunction

    // Sends one command word in bursts with random gaps.
    task automatic send_command(logic clear, logic [31:0] fx, logic [31:0] fy,
                                logic [31:0] tz);
        velocity_t pred;
        if (burst_left == 0)
        begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            burst_left = $urandom_range(1, 10);
        end
        while (gap_left > 0)
        begin
            @(posedge clk);
            gap_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= clear;
        s_axis_tdata  <= {tz, fy, fx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = next_velocity(clear, {tz, fy, fx});
        expected_q = {expected_q, pred};
        burst_left--;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until the block is idle, then writes one register.
    task automatic write_register(logic [1:0] idx, logic [30:0] val);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mvul_pkg::REG_TIME_STEP)
            step_reg = val & 31'h1FFFF;
        else if (idx == mvul_pkg::REG_SPEED_LIMIT)
            speed_reg = val;
        else if (idx == mvul_pkg::REG_ACCEL_LIMIT)
            accel_reg = val;
    endtask

    function automatic logic [31:0] rand_force();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_command(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_command(1'b0, 32'h80000000, 32'h80000000, 32'h80000000);
        send_command(1'b0, 32'h0, 32'h0, 32'h0);
        send_command(1'b0, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        send_command(1'b0, 32'h00010000, 32'hFFFF0000, 32'h00008000);
        send_command(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_command(1'b0, 32'h00000010, 32'hFFFFFFF0, 32'h00000030);
    endtask

    task automatic test_zero_limits();
        write_register(mvul_pkg::REG_ACCEL_LIMIT, 31'd0);
        send_command(1'b0, 32'h00100000, 32'h0, 32'h0);
        send_command(1'b0, 32'h0, 32'h0, 32'h0);
        write_register(mvul_pkg::REG_ACCEL_LIMIT, 31'h7FFFFFFF);
        write_register(mvul_pkg::REG_SPEED_LIMIT, 31'h7FFFFFFF);
        write_register(mvul_pkg::REG_TIME_STEP, 31'h7FFF0000);
        send_command(1'b0, 32'h7FFFFFFF, 32'h0, 32'h0);
        send_command(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        write_register(mvul_pkg::REG_TIME_STEP, 31'd65536);
        write_register(mvul_pkg::REG_SPEED_LIMIT, 31'd0);
        send_command(1'b0, 32'h00200000, 32'h00100000, 32'h0);
        write_register(mvul_pkg::REG_TIME_STEP, 31'd0);
        send_command(1'b0, 32'h00200000, 32'h00100000, 32'h0);
        write_register(REG_INDEX_UNUSED, 31'h1234567);
    endtask

    task automatic test_random_phase(int count, int step, int spd, int acc);
        write_register(mvul_pkg::REG_TIME_STEP, 31'(step));
        write_register(mvul_pkg::REG_SPEED_LIMIT, 31'(spd));
        write_register(mvul_pkg::REG_ACCEL_LIMIT, 31'(acc));
        repeat (count)
            send_command($urandom_range(0, 15) == 0, rand_force(), rand_force(),
                         rand_force());
    endtask

    // Receiver stalls on its own random pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 7) != 0) || (cycle[9:7] == 3'd5);
    end

    // Checks each result word against the oldest prediction.
    always @(posedge clk)
    begin
        velocity_t exp_v;
        velocity_t got;
        if (!rst_n)
            cycle <= 0;
        else
            cycle <= cycle + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tuser[0], m_axis_tuser[1]};
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_v = expected_q.pop_front();
                if (got.vx !== exp_v.vx)
                    $display("%0t vel_x: expected %h, actual %h", $time, exp_v.vx, got.vx);
                if (got.vy !== exp_v.vy)
                    $display("%0t vel_y: expected %h, actual %h", $time, exp_v.vy, got.vy);
                if (got.wz !== exp_v.wz)
                    $display("%0t yaw_rate: expected %h, actual %h", $time, exp_v.wz, got.wz);
                if (got.acc_lim !== exp_v.acc_lim)
                    $display("%0t accel_limited: expected %b, actual %b", $time,
                             exp_v.acc_lim, got.acc_lim);
                if (got.spd_lim !== exp_v.spd_lim)
                    $display("%0t speed_limited: expected %b, actual %b", $time,
                             exp_v.spd_lim, got.spd_lim);
                if (got !== exp_v)
                    errors++;
            end
        end
        if (rst_n && cycle > MAX_CYCLE)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        burst_left = 0;
        gap_left = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (vel_state[i])
            vel_state[i] = 0;
        step_reg = mvul_pkg::TIME_STEP_RST;
        speed_reg = mvul_pkg::SPEED_LIMIT_RST;
        accel_reg = mvul_pkg::ACCEL_LIMIT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_zero_limits();
        test_random_phase(250, mvul_pkg::TIME_STEP_RST, mvul_pkg::SPEED_LIMIT_RST,
                          mvul_pkg::ACCEL_LIMIT_RST);
        test_random_phase(150, 65536, 'h7FFFFFFF, 'h7FFFFFFF);
        test_random_phase(150, 13107, 200000, 1000000);
        test_random_phase(100, 'h1FFFF, 1, 1);
        test_random_phase(100, $urandom_range(0, 65536), $urandom(), $urandom());
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
